@@ design/crt_pkg.sv @@
// Shared types and constants of the cache set replacement tracker.
package crt_pkg;

  localparam int BLOCK_W   = 32;
  localparam int SET_W     = 12;
  localparam int RESULT_W  = 16;
  localparam int WAYS_W    = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_WAYS   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POLICY = 1'd1;

  // Values after reset.
  localparam logic [WAYS_W-1:0] WAYS_RESET = 5'd4;
  localparam logic              POLICY_LRU = 1'b1;
  localparam logic              POLICY_FIFO = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ design/crt_if.sv @@
// Channel interfaces of the cache set replacement tracker.
interface crt_req_if;
  logic                          valid;
  logic                          ready;
  logic [crt_pkg::BLOCK_W-1:0]   block_number;
  logic [crt_pkg::SET_W-1:0]     set_index;

  modport source (output valid, output block_number, output set_index, input ready);
  modport sink (input valid, input block_number, input set_index, output ready);
endinterface

interface crt_resp_if;
  logic                          valid;
  logic                          ready;
  logic [crt_pkg::RESULT_W-1:0]  cache_block;
  logic                          hit;
  logic                          replaced;

  modport source (output valid, output cache_block, output hit, output replaced, input ready);
  modport sink (input valid, input cache_block, input hit, input replaced, output ready);
endinterface

interface crt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [crt_pkg::CFG_ADDR_W-1:0]  addr;
  logic [crt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

@@ design/cache_set_replacement_tracker.sv @@
// Top level of the cache set replacement tracker.
//
// The tracker keeps the age-ordered list of blocks held in one cache set and
// answers each access with the cache block number it occupies. Accesses come
// in on the req channel (block number and set index), and one result per access
// leaves on the resp channel (cache block, hit and replaced flags). Each
// transaction completes when valid and ready are both high at a clock edge.
// The cfg channel writes the ways and policy registers and is always ready;
// the user must use it only while no access is in flight; not enforced here.
// The tag compare checks every entry at once in the cycle the access is
// accepted and registers the match flags. The list update follows in the
// update state, which shifts the ordered list and loads the result register.
// The result is valid once the result register is loaded, and a new access
// is accepted only after the previous one has been updated, set by this
// compare and update pair. If the receiver stalls, the finished result waits in
// the result register while the next access is accepted and compared; its
// update then waits until the result register is free.
// Reset is synchronous: it empties the list, sets ways to four and selects LRU
// order. Entry storage needs no clearing pass since only filled entries are read.
module cache_set_replacement_tracker #(
  parameter int MAX_WAYS = 16
) (
  input  logic            clk,
  input  logic            rst,
  crt_req_if.sink         req,
  crt_resp_if.source      resp,
  crt_cfg_if.sink         cfg
);

  crt_pkg::cmd_t    cmd;
  crt_pkg::status_t status;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  crt_dpath #(
    .MAX_WAYS (MAX_WAYS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .block_number (req.block_number),
    .set_index    (req.set_index),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_addr     (cfg.addr),
    .cfg_data     (cfg.data),
    .out_valid    (resp.valid),
    .out_ready    (resp.ready),
    .cache_block  (resp.cache_block),
    .hit          (resp.hit),
    .replaced     (resp.replaced)
  );

endmodule

@@ design/crt_ctrl.sv @@
// Controller state machine of the cache set replacement tracker.
module crt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  crt_pkg::status_t  status,
  output crt_pkg::cmd_t     cmd
);

  crt_pkg::state_t state;
  crt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      crt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = crt_pkg::ST_UPDATE;
        end
      end
      crt_pkg::ST_UPDATE: begin
        // Hold the list update until the result register can take the result.
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = crt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = crt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/crt_dpath.sv @@
// Datapath of the cache set replacement tracker: entry list, tag compare, result register.
module crt_dpath #(
  parameter int MAX_WAYS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  crt_pkg::cmd_t                  cmd,
  output crt_pkg::status_t               status,
  input  logic [crt_pkg::BLOCK_W-1:0]    block_number,
  input  logic [crt_pkg::SET_W-1:0]      set_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crt_pkg::RESULT_W-1:0]   cache_block,
  output logic                           hit,
  output logic                           replaced
);

  localparam int SLOT_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int SUM_W  = crt_pkg::SET_W + crt_pkg::WAYS_W + 1;

  logic [crt_pkg::WAYS_W-1:0]  ways;
  logic                        policy_lru;

  logic [crt_pkg::BLOCK_W-1:0] entry_block [MAX_WAYS];
  logic [SLOT_W-1:0]           entry_slot  [MAX_WAYS];
  logic [CNT_W-1:0]            entry_count;

  logic [crt_pkg::BLOCK_W-1:0] blk_q;
  logic [crt_pkg::SET_W-1:0]   set_q;
  logic [MAX_WAYS-1:0]         match_q;

  logic [crt_pkg::WAYS_W-1:0]  eff_ways;
  logic                        found;
  logic                        full;
  logic                        rotate;
  logic                        fill;
  logic [SLOT_W-1:0]           pos;
  logic [SLOT_W-1:0]           rpos;
  logic [SLOT_W-1:0]           last_idx;
  logic [SLOT_W-1:0]           fill_idx;
  logic [SLOT_W-1:0]           res_slot;
  logic [SUM_W-1:0]            sum;
  logic [crt_pkg::BLOCK_W-1:0] up_block [MAX_WAYS];
  logic [SLOT_W-1:0]           up_slot  [MAX_WAYS];

  // Configuration registers; the user writes only while the tracker is idle; not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways       <= crt_pkg::WAYS_RESET;
      policy_lru <= crt_pkg::POLICY_LRU;
    end else if (cfg_valid) begin
      case (cfg_addr)
        crt_pkg::REG_WAYS:   ways <= cfg_data;
        crt_pkg::REG_POLICY: policy_lru <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ways == '0) begin
      eff_ways = crt_pkg::WAYS_W'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      eff_ways = crt_pkg::WAYS_W'(MAX_WAYS);
    end else begin
      eff_ways = ways;
    end
  end

  // Capture the access and compare its block number against every valid entry.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk_q <= block_number;
      set_q <= set_index;
      for (int i = 0; i < MAX_WAYS; i++) begin
        match_q[i] <= (entry_block[i] == block_number) && (int'(entry_count) > i);
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        pos = SLOT_W'(i);
      end
    end
  end

  assign found    = |match_q;
  assign full     = int'(entry_count) >= int'(eff_ways);
  assign rotate   = (found && (policy_lru == crt_pkg::POLICY_LRU)) || (!found && full);
  assign fill     = !found && !full;
  assign rpos     = found ? pos : '0;
  assign last_idx = SLOT_W'(entry_count - CNT_W'(1));
  assign fill_idx = SLOT_W'(entry_count);
  assign res_slot = (found || full) ? entry_slot[rpos] : fill_idx;
  assign sum      = SUM_W'(set_q) * SUM_W'(eff_ways) + SUM_W'(res_slot);

  // Each entry's neighbor toward the young end, for the shift of the list.
  always_comb begin
    for (int i = 0; i < MAX_WAYS - 1; i++) begin
      up_block[i] = entry_block[i + 1];
      up_slot[i]  = entry_slot[i + 1];
    end
    up_block[MAX_WAYS-1] = entry_block[MAX_WAYS-1];
    up_slot[MAX_WAYS-1]  = entry_slot[MAX_WAYS-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (rotate) begin
          if (SLOT_W'(i) == last_idx) begin
            entry_block[i] <= blk_q;
            entry_slot[i]  <= res_slot;
          end else if (SLOT_W'(i) >= rpos && SLOT_W'(i) < last_idx) begin
            entry_block[i] <= up_block[i];
            entry_slot[i]  <= up_slot[i];
          end
        end else if (fill && SLOT_W'(i) == fill_idx) begin
          entry_block[i] <= blk_q;
          entry_slot[i]  <= fill_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.commit && fill) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cache_block <= sum[crt_pkg::RESULT_W-1:0];
      hit         <= found;
      replaced    <= !found && full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the cache set replacement tracker.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_WAYS = 16;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 117;
  localparam int POOL = 20;
  // The slowest correct stretch without any transaction is one long sender gap
  // or one long receiver stall, plus the compare and update pipeline and the
  // short settle before a register write; this limit is many times that.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [crt_pkg::BLOCK_W-1:0] block_number;
    logic [crt_pkg::SET_W-1:0]   set_index;
  } access_t;

  typedef struct packed {
    logic [crt_pkg::RESULT_W-1:0] cache_block;
    logic                         hit;
    logic                         replaced;
  } lookup_t;

  logic clk;
  logic rst;

  crt_req_if  req();
  crt_resp_if resp();
  crt_cfg_if  cfg();

  cache_set_replacement_tracker #(
    .MAX_WAYS(MAX_WAYS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .resp(resp),
    .cfg (cfg)
  );

  // Register settings for each phase after the directed part. The sequence
  // fills sixteen ways and then drops to two, so the list holds more entries
  // than the set allows; zero and values above sixteen check the clamping.
  int   ways_plan[PHASES] = '{16, 2, 0, 31, 1, 8, 17, 16, 3, 5, 12};
  logic policy_plan[PHASES] = '{crt_pkg::POLICY_LRU, crt_pkg::POLICY_LRU,
                                crt_pkg::POLICY_FIFO, crt_pkg::POLICY_LRU,
                                crt_pkg::POLICY_FIFO, crt_pkg::POLICY_LRU,
                                crt_pkg::POLICY_FIFO, crt_pkg::POLICY_FIFO,
                                crt_pkg::POLICY_LRU, crt_pkg::POLICY_FIFO,
                                crt_pkg::POLICY_LRU};

  // Accesses waiting to be sent, and results predicted for accepted accesses.
  access_t access_q[$];
  lookup_t expected_lookups[$];

  // Blocks that are reused often so that hits and evictions happen.
  logic [crt_pkg::BLOCK_W-1:0] hot_blocks[POOL];

  // When set, neither side inserts gaps or stalls.
  logic steady;

  int error_count = 0;
  int send_gap;
  int stall_left;
  int idle_cycles;

  // Mirror of the tracker: registers and the age-ordered list, oldest first.
  logic [crt_pkg::WAYS_W-1:0]  ways_reg;
  logic                        lru_mode;
  logic [crt_pkg::BLOCK_W-1:0] held_block[MAX_WAYS];
  logic [3:0]                  held_slot[MAX_WAYS];
  int                          held_count;

  always #4 clk = ~clk;

  task automatic flag_error(input string what);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return int'($urandom_range(1, 3));
    else return int'($urandom_range(8, 40));
  endfunction

  // A ways value of zero acts as one, and values past the maximum are clamped.
  function automatic int effective_ways(input logic [crt_pkg::WAYS_W-1:0] w);
    if (w == 0) return 1;
    if (int'(w) > MAX_WAYS) return MAX_WAYS;
    return int'(w);
  endfunction

  // Takes the entry at pos out of the list and appends the given block and
  // slot as the youngest entry.
  function automatic void move_to_youngest(input int pos,
                                           input logic [crt_pkg::BLOCK_W-1:0] blk,
                                           input logic [3:0] slot);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_block[i] = held_block[i + 1];
      held_slot[i]  = held_slot[i + 1];
    end
    held_block[held_count - 1] = blk;
    held_slot[held_count - 1]  = slot;
  endfunction

  // Looks up one access in the mirrored list, updates the list and returns
  // the result the tracker has to give.
  function automatic lookup_t track_access(input access_t a);
    lookup_t r;
    int      w;
    int      pos;
    int      slot;
    int      sum;
    bit      found;
    r     = '0;
    w     = effective_ways(ways_reg);
    found = 1'b0;
    pos   = 0;
    slot  = 0;
    for (int i = 0; i < held_count; i++) begin
      if (!found && held_block[i] == a.block_number) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      // A hit answers with the entry's own slot, even when ways was lowered.
      r.hit = 1'b1;
      slot  = int'(held_slot[pos]);
      if (lru_mode == crt_pkg::POLICY_LRU) begin
        move_to_youngest(pos, a.block_number, held_slot[pos]);
      end
    end else if (held_count < w) begin
      slot = held_count;
      held_block[held_count] = a.block_number;
      held_slot[held_count]  = 4'(slot);
      held_count++;
    end else begin
      // Full set, or more entries than the current ways: the oldest goes and
      // the count stays as it is.
      slot = int'(held_slot[0]);
      move_to_youngest(0, a.block_number, held_slot[0]);
      r.replaced = 1'b1;
    end
    sum = int'(a.set_index) * w + slot;
    r.cache_block = sum[crt_pkg::RESULT_W-1:0];
    return r;
  endfunction

  // Access driver. A new access is presented once the previous one has been
  // taken, after a random gap unless steady mode is on.
  always @(posedge clk) begin : drive_access
    access_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      send_gap  <= 0;
    end else if (!req.valid || req.ready) begin
      if (send_gap != 0 || access_q.size() == 0) begin
        req.valid <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
      end else begin
        nxt = access_q.pop_front();
        req.valid        <= 1'b1;
        req.block_number <= nxt.block_number;
        req.set_index    <= nxt.set_index;
        send_gap         <= steady ? 0 : draw_gap();
      end
    end
  end

  // Result receiver. Ready drops for random stretches so that stalls fall
  // on every phase of the compare and update pair.
  always @(posedge clk) begin
    if (rst) begin
      resp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      resp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      resp.ready <= 1'b1;
      if (!steady && $urandom_range(0, 5) == 0) stall_left <= draw_gap();
    end
  end

  // Monitor. Every transaction is seen at the clock edge that completes it:
  // register writes update the mirror, accepted accesses are predicted, and
  // each result is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    access_t acc;
    lookup_t pred;
    lookup_t want;
    if (rst) begin
      ways_reg   <= crt_pkg::WAYS_RESET;
      lru_mode   <= crt_pkg::POLICY_LRU;
      held_count = 0;
      expected_lookups.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.addr == crt_pkg::REG_WAYS) ways_reg <= cfg.data[crt_pkg::WAYS_W-1:0];
        else if (cfg.addr == crt_pkg::REG_POLICY) lru_mode <= cfg.data[0];
      end
      if (req.valid && req.ready) begin
        acc.block_number = req.block_number;
        acc.set_index    = req.set_index;
        pred = track_access(acc);
        expected_lookups.insert(expected_lookups.size(), pred);
      end
      if (resp.valid && resp.ready) begin
        if (expected_lookups.size() == 0) begin
          flag_error($sformatf("result with no access outstanding: cache_block %0d",
                               resp.cache_block));
        end else begin
          want = expected_lookups.pop_front();
          if (resp.cache_block !== want.cache_block)
            flag_error($sformatf("cache_block %0d, expected %0d", resp.cache_block,
                                 want.cache_block));
          if (resp.hit !== want.hit)
            flag_error($sformatf("hit %b, expected %b", resp.hit, want.hit));
          if (resp.replaced !== want.replaced)
            flag_error($sformatf("replaced %b, expected %b", resp.replaced, want.replaced));
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind completes for
  // too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (resp.valid && resp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_access(input logic [crt_pkg::BLOCK_W-1:0] blk,
                              input logic [crt_pkg::SET_W-1:0] set);
    access_t a;
    a.block_number = blk;
    a.set_index    = set;
    access_q.insert(access_q.size(), a);
  endtask

  // Waits until every access has been sent and answered, then lets a few
  // more cycles pass so that a stray extra result would still be caught.
  task automatic wait_until_drained(input int settle);
    do @(negedge clk);
    while (access_q.size() != 0 || req.valid || expected_lookups.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Register writes are only issued while the tracker is idle.
  task automatic write_register(input logic [crt_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [crt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.addr  <= addr;
    cfg.data  <= data;
    do @(posedge clk);
    while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Random access: mostly blocks from the hot pool (limited to a few more
  // than the ways in use, so hits and evictions both occur), some extremes,
  // some fresh values that touch every bit.
  task automatic queue_random_access(input int hot);
    logic [crt_pkg::BLOCK_W-1:0] blk;
    logic [crt_pkg::SET_W-1:0]   set;
    int                          r;
    r = $urandom_range(0, 99);
    if (r < 75) blk = hot_blocks[$urandom_range(0, hot)];
    else if (r < 83) blk = $urandom_range(0, 1) ? '1 : '0;
    else blk = $urandom();
    r = $urandom_range(0, 99);
    if (r < 5) set = '0;
    else if (r < 10) set = '1;
    else set = crt_pkg::SET_W'($urandom_range(0, 4095));
    queue_access(blk, set);
    if ($urandom_range(0, 15) == 0) hot_blocks[$urandom_range(0, POOL - 1)] = $urandom();
  endtask

  initial begin : stimulus
    int hot;
    int done;
    int chunk;
    clk              = 1'b0;
    rst              = 1'b1;
    steady           = 1'b0;
    req.valid        = 1'b0;
    req.block_number = '0;
    req.set_index    = '0;
    resp.ready       = 1'b0;
    cfg.valid        = 1'b0;
    cfg.addr         = '0;
    cfg.data         = '0;
    for (int i = 0; i < POOL; i++) hot_blocks[i] = $urandom();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset settings (four ways, LRU): fill the set with
    // extreme block numbers and set indexes, hit the oldest entry so it becomes
    // youngest, miss twice to evict the two oldest, then mix hits and misses.
    queue_access('0, '0);
    queue_access('1, '1);
    queue_access(32'h1234_5678, 12'd1);
    queue_access(32'hA5A5_A5A5, 12'd2);
    queue_access('0, 12'd3);
    queue_access(32'hDEAD_BEEF, '1);
    queue_access(32'h5A5A_5A5A, '0);
    queue_access(32'hDEAD_BEEF, 12'd7);
    queue_access('0, 12'd2048);
    queue_access('1, 12'd4094);
    queue_access(32'h8000_0000, 12'd100);
    queue_access(32'h0000_0001, 12'd1023);
    wait_until_drained(4);

    for (int p = 0; p < PHASES; p++) begin
      write_register(crt_pkg::REG_WAYS, crt_pkg::CFG_DATA_W'(ways_plan[p]));
      write_register(crt_pkg::REG_POLICY,
                     {{(crt_pkg::CFG_DATA_W - 1){1'b0}}, policy_plan[p]});
      @(negedge clk);
      hot  = effective_ways(crt_pkg::WAYS_W'(ways_plan[p])) + 2;
      if (hot > POOL - 1) hot = POOL - 1;
      done = 0;
      while (done < PHASE_ITEMS) begin
        chunk  = $urandom_range(10, 40);
        steady = ($urandom_range(0, 4) == 0);
        repeat (chunk) queue_random_access(hot);
        done += chunk;
        // Occasionally hold back until every result is in before going on.
        if ($urandom_range(0, 9) == 0) wait_until_drained(0);
      end
      steady = 1'b0;
      wait_until_drained(4);
    end

    wait_until_drained(8);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/crt_pkg.sv
design/crt_if.sv
design/crt_ctrl.sv
design/crt_dpath.sv
design/cache_set_replacement_tracker.sv
tb/testbench.sv
